// ===== design/mcpf_pkg.sv =====
`default_nettype none

package mcpf_pkg;

  localparam int VOLT_WIDTH_DEF = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W = 2;
  localparam int SPEED_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_REAR_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd2;

  localparam logic [7:0] REAR_ADDR_RST  = 8'd128;
  localparam logic [7:0] FRONT_ADDR_RST = 8'd129;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 7'd127;

  localparam logic [MODE_W-1:0] MODE_APPLY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DONE  = 2'd2;

  localparam logic [7:0] CMD_CH1_FWD = 8'd0;
  localparam logic [7:0] CMD_CH1_REV = 8'd1;
  localparam logic [7:0] CMD_CH2_FWD = 8'd4;
  localparam logic [7:0] CMD_CH2_REV = 8'd5;
  localparam logic [7:0] CMD_TIMEOUT = 8'd14;
  localparam logic [SPEED_W-1:0] TIMEOUT_VALUE = 7'd3;

  localparam int PKT_LEN = 4;
  localparam int NUM_LANES = 4;
  localparam int BURST_MAX = PKT_LEN * NUM_LANES;
  localparam int CNT_W = $clog2(BURST_MAX + 1);

  // magnitudes at or above this saturate the speed at 127
  localparam int SAT_MAG = 3085;
  localparam int MAG_LO_W = 12;

  // round(mag * 127 / 3072) = (254 * mag + 3072) / 6144, split as >> 11 then / 3
  function automatic logic [SPEED_W-1:0] volt_speed(input logic [MAG_LO_W-1:0] mag,
                                                    input logic sat,
                                                    input logic [SPEED_W-1:0] max_spd);
    logic [19:0] x;
    logic [16:0] p;
    logic [SPEED_W-1:0] s;
    x = 20'(mag) * 20'd254 + 20'd3072;
    p = 17'(x[19:11]) * 17'd171;
    s = sat ? 7'd127 : p[15:9];
    return (s > max_spd) ? max_spd : s;
  endfunction

  function automatic logic [7:0] checksum7(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [9:0] sum;
    sum = 10'(a) + 10'(b) + 10'(c);
    return {1'b0, sum[6:0]};
  endfunction

endpackage

`default_nettype wire

// ===== design/motor_command_packet_framer_top.sv =====
// Channel  | Signals                      | Contents (lowest bit first)
// s_       | tvalid tready tdata tuser    | tdata: rear_left, rear_right, front_left,
//          |                              | front_right volts; tuser: mode
// m_       | tvalid tready tdata tlast    | tdata: tx_byte; tlast: last_byte
// cfg_     | we index data                | 0 rear_address, 1 front_address, 2 max_speed
//
// One command per cycle enters the input register while s_tready is high; it is
// turned into packet bytes in one pass and loaded into a 16-byte shift register
// behind the output port. An apply burst is 16 bytes, init 8; done, dropped and
// unused commands produce no bytes. The output byte port sets the rate.
// Reset is synchronous: busy clears, config registers return to their reset values.
// Either side may stall at any time; the input register takes the next command
// while the current burst drains.
`default_nettype none

module motor_command_packet_framer_top
  import mcpf_pkg::*;
#(
  parameter int VOLT_WIDTH = VOLT_WIDTH_DEF,
  localparam int IN_W = ((NUM_LANES * VOLT_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_W-1:0]       s_tdata,   // rl, rr, fl, fr volts, zero pad
  input  wire logic [MODE_W-1:0]     s_tuser,   // mode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // tx_byte
  output logic                       m_tlast,   // last_byte
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MW = (VOLT_WIDTH > MAG_LO_W) ? VOLT_WIDTH : MAG_LO_W;

  logic [7:0] rear_addr;
  logic [7:0] front_addr;
  logic [SPEED_W-1:0] max_speed;
  logic busy;

  logic hold_valid;
  logic [MODE_W-1:0] hold_mode;
  logic [VOLT_WIDTH-1:0] hold_volts [NUM_LANES];

  logic [7:0] bytes [BURST_MAX];
  logic [CNT_W-1:0] remaining;

  logic [7:0] pkt_bytes [BURST_MAX];
  logic produces;
  logic ser_free;
  logic consume;
  logic load;

  assign m_tvalid = (remaining != '0);
  assign m_tdata  = bytes[0];
  assign m_tlast  = (remaining == CNT_W'(1));

  assign produces = ((hold_mode == MODE_APPLY) || (hold_mode == MODE_INIT)) && !busy;
  assign ser_free = (remaining == '0) || ((remaining == CNT_W'(1)) && m_tready);
  assign consume  = hold_valid && (ser_free || !produces);
  assign load     = consume && produces;
  assign s_tready = !hold_valid || consume;

  always_comb begin
    logic [VOLT_WIDTH-1:0] mag;
    logic [MW-1:0] mag_ext;
    logic neg;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [SPEED_W-1:0] spd;
    mag     = '0;
    mag_ext = '0;
    neg     = 1'b0;
    addr    = '0;
    cmd     = '0;
    spd     = '0;
    for (int i = 0; i < BURST_MAX; i++) begin
      pkt_bytes[i] = '0;
    end
    if (hold_mode == MODE_INIT) begin
      for (int p = 0; p < 2; p++) begin
        addr = (p == 0) ? rear_addr : front_addr;
        spd  = (TIMEOUT_VALUE > max_speed) ? max_speed : TIMEOUT_VALUE;
        pkt_bytes[p*PKT_LEN]     = addr;
        pkt_bytes[p*PKT_LEN + 1] = CMD_TIMEOUT;
        pkt_bytes[p*PKT_LEN + 2] = {1'b0, spd};
        pkt_bytes[p*PKT_LEN + 3] = checksum7(addr, CMD_TIMEOUT, {1'b0, spd});
      end
    end else begin
      for (int p = 0; p < NUM_LANES; p++) begin
        neg     = hold_volts[p][VOLT_WIDTH-1];
        mag     = neg ? (~hold_volts[p] + VOLT_WIDTH'(1)) : hold_volts[p];
        mag_ext = MW'(mag);
        spd     = volt_speed(mag_ext[MAG_LO_W-1:0], (mag_ext >= MW'(SAT_MAG)), max_speed);
        addr    = (p < 2) ? rear_addr : front_addr;
        if (p % 2 == 1) begin
          cmd = neg ? CMD_CH2_REV : CMD_CH2_FWD;
        end else begin
          cmd = neg ? CMD_CH1_REV : CMD_CH1_FWD;
        end
        pkt_bytes[p*PKT_LEN]     = addr;
        pkt_bytes[p*PKT_LEN + 1] = cmd;
        pkt_bytes[p*PKT_LEN + 2] = {1'b0, spd};
        pkt_bytes[p*PKT_LEN + 3] = checksum7(addr, cmd, {1'b0, spd});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rear_addr  <= REAR_ADDR_RST;
      front_addr <= FRONT_ADDR_RST;
      max_speed  <= MAX_SPEED_RST;
      busy       <= 1'b0;
      hold_valid <= 1'b0;
      remaining  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REAR_ADDR:  rear_addr  <= cfg_data;
          REG_FRONT_ADDR: front_addr <= cfg_data;
          REG_MAX_SPEED:  max_speed  <= cfg_data[SPEED_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end

      if (consume) begin
        if (hold_mode == MODE_DONE) begin
          busy <= 1'b0;
        end else if (produces) begin
          busy <= 1'b1;
        end
      end

      if (load) begin
        remaining <= (hold_mode == MODE_INIT) ? CNT_W'(2 * PKT_LEN) : CNT_W'(BURST_MAX);
      end else if (m_tvalid && m_tready) begin
        remaining <= remaining - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_mode <= s_tuser;
      for (int i = 0; i < NUM_LANES; i++) begin
        hold_volts[i] <= s_tdata[i*VOLT_WIDTH +: VOLT_WIDTH];
      end
    end

    if (load) begin
      for (int i = 0; i < BURST_MAX; i++) begin
        bytes[i] <= pkt_bytes[i];
      end
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < BURST_MAX - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[BURST_MAX-1] <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== test/motor_command_packet_framer_top_tb.sv =====
`timescale 1ns / 100ps

module motor_command_packet_framer_top_tb;
  import mcpf_pkg::*;

  localparam int VW = VOLT_WIDTH_DEF;
  localparam int IN_W = ((NUM_LANES * VW + 7) / 8) * 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } tx_byte_t;

  class framer_scoreboard;
    logic [7:0]         rear_addr;
    logic [7:0]         front_addr;
    logic [SPEED_W-1:0] max_spd;
    bit                 busy;
    tx_byte_t           pending_bytes[$];
    int                 mismatches;

    function new();
      rear_addr  = REAR_ADDR_RST;
      front_addr = FRONT_ADDR_RST;
      max_spd    = MAX_SPEED_RST;
      busy       = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_REAR_ADDR:  rear_addr = val;
        REG_FRONT_ADDR: front_addr = val;
        REG_MAX_SPEED:  max_spd = val[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SPEED_W-1:0] clamp_speed(int unsigned spd);
      if (spd > 127) spd = 127;
      if (spd > max_spd) spd = max_spd;
      return SPEED_W'(spd);
    endfunction

    function void push_packet(logic [7:0] addr, logic [7:0] cmd, logic [SPEED_W-1:0] spd,
                              bit last);
      logic [7:0] sum;
      sum = addr + cmd + 8'(spd);
      pending_bytes.push_back({addr, 1'b0});
      pending_bytes.push_back({cmd, 1'b0});
      pending_bytes.push_back({8'(spd), 1'b0});
      pending_bytes.push_back({{1'b0, sum[6:0]}, last});
    endfunction

    // Burst expected for one accepted command.
    function void note_command(logic [MODE_W-1:0] mode, logic [IN_W-1:0] volts);
      logic [VW-1:0] v;
      int unsigned   mag;
      logic [7:0]    cmd;
      if (mode == MODE_DONE) begin
        busy = 1'b0;
        return;
      end
      if (mode == MODE_UNUSED || busy) return;
      busy = 1'b1;
      if (mode == MODE_INIT) begin
        push_packet(rear_addr, CMD_TIMEOUT, clamp_speed(TIMEOUT_VALUE), 1'b0);
        push_packet(front_addr, CMD_TIMEOUT, clamp_speed(TIMEOUT_VALUE), 1'b1);
        return;
      end
      for (int i = 0; i < NUM_LANES; i++) begin
        v = volts[i*VW +: VW];
        mag = v[VW-1] ? (32'd1 << VW) - 32'(v) : 32'(v);
        if (i % 2 == 1) cmd = v[VW-1] ? CMD_CH2_REV : CMD_CH2_FWD;
        else cmd = v[VW-1] ? CMD_CH1_REV : CMD_CH1_FWD;
        push_packet((i < 2) ? rear_addr : front_addr, cmd,
                    clamp_speed((mag * 254 + 3072) / 6144), i == NUM_LANES - 1);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_byte(logic [7:0] tx, logic last);
      tx_byte_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", tx, last));
        return;
      end
      want = pending_bytes.pop_front();
      if (tx !== want.tx)
        report_mismatch($sformatf("tx_byte %02h, wanted %02h", tx, want.tx));
      if (last !== want.last)
        report_mismatch($sformatf("last_byte %0b, wanted %0b", last, want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [IN_W-1:0]       s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire  [7:0]            m_tdata;
  wire                   m_tlast;

  framer_scoreboard sb = new();
  int burst_left = 0;
  int sent_items = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  motor_command_packet_framer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver backpressure: stretches of always-ready, light, heavy and alternating stalls
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= $urandom_range(16, 96);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ~m_tready;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
  end

  function automatic logic [IN_W-1:0] pack_volts(logic [VW-1:0] rl, logic [VW-1:0] rr,
                                                 logic [VW-1:0] fl, logic [VW-1:0] fr);
    return IN_W'({fr, fl, rr, rl});
  endfunction

  function automatic logic [VW-1:0] random_volt();
    case ($urandom_range(0, 5))
      0, 1: return VW'($urandom);
      2: return VW'($urandom_range(0, 3200));
      3: return -VW'($urandom_range(0, 3200));
      4: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(VW-1){1'b0}}};
          1: return {1'b0, {(VW-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 1) return -VW'($urandom_range(1500, 1570));
        return VW'($urandom_range(1500, 1570));
      end
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_volts();
    return pack_volts(random_volt(), random_volt(), random_volt(), random_volt());
  endfunction

  task automatic send_command(logic [MODE_W-1:0] mode, logic [IN_W-1:0] volts);
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= volts;
    do @(posedge clk); while (!s_tready);
    sb.note_command(mode, volts);
    if (mode != MODE_UNUSED) sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(0, 6);
    end
  endtask

  task automatic send_request();
    send_command(($urandom_range(0, 4) == 0) ? MODE_INIT : MODE_APPLY, random_volts());
  endtask

  task automatic drain(int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] rear, logic [7:0] front, logic [SPEED_W-1:0] spd);
    cfg_we <= 1'b1;
    cfg_index <= REG_REAR_ADDR;
    cfg_data <= rear;
    @(posedge clk);
    cfg_index <= REG_FRONT_ADDR;
    cfg_data <= front;
    @(posedge clk);
    cfg_index <= REG_MAX_SPEED;
    cfg_data <= CFG_DATA_W'(spd);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_REAR_ADDR, rear);
    sb.write_reg(REG_FRONT_ADDR, front);
    sb.write_reg(REG_MAX_SPEED, CFG_DATA_W'(spd));
  endtask

  task automatic run_random(int n_items);
    int stop_at;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5, 6: begin
          send_request();
          send_command(MODE_DONE, random_volts());
        end
        7: begin
          send_request();
          send_request();
          send_command(MODE_DONE, random_volts());
        end
        8: send_command(MODE_DONE, random_volts());
        9: send_command(MODE_UNUSED, random_volts());
        10: begin
          send_request();
          send_command(MODE_UNUSED, random_volts());
          send_command(MODE_DONE, random_volts());
        end
        default: drain(0);
      endcase
    end
  endtask

  task automatic run_directed();
    send_command(MODE_APPLY, pack_volts(16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF));
    send_command(MODE_DONE, '0);
    // exact half-way rounding at 1536
    send_command(MODE_APPLY, pack_volts(16'd1536, -16'd1536, 16'd1535, -16'd1535));
    send_command(MODE_DONE, '1);
    // saturation threshold
    send_command(MODE_APPLY, pack_volts(16'd3084, 16'd3085, -16'd3084, -16'd3085));
    send_command(MODE_APPLY, random_volts());
    send_command(MODE_INIT, random_volts());
    send_command(MODE_DONE, '0);
    send_command(MODE_DONE, '0);
    send_command(MODE_UNUSED, random_volts());
    send_command(MODE_INIT, '0);
    send_command(MODE_DONE, '0);
    send_command(MODE_APPLY, pack_volts(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0));
    send_command(MODE_UNUSED, '1);
    send_command(MODE_DONE, '0);
    send_command(MODE_APPLY, pack_volts(16'd1, -16'd1, 16'd2, -16'd2));
    send_command(MODE_APPLY, '0);
    send_command(MODE_DONE, '0);
    send_command(MODE_INIT, '1);
    send_command(MODE_DONE, '1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(20);
    for (int phase = 0; phase < 6; phase++) begin
      drain(SETTLE_CYCLES);
      case (phase)
        0: write_regs(8'h00, 8'hFF, 7'd127);
        1: write_regs(8'hFF, 8'h00, 7'd0);
        2: write_regs(8'($urandom), 8'($urandom), 7'd3);
        3: write_regs(8'($urandom), 8'($urandom), 7'd2);
        4: write_regs(8'($urandom), 8'($urandom), SPEED_W'($urandom_range(1, 126)));
        default: write_regs(REAR_ADDR_RST, FRONT_ADDR_RST, MAX_SPEED_RST);
      endcase
      run_random(23);
    end
    drain(SETTLE_CYCLES);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
